// ===== hw/rtl/taf_pkg.sv =====
// Package: shared types, constants and fixed-point helpers of the abreast formation block.
`default_nettype none
package taf_pkg;

    localparam int FRAC_BITS = 16;
    localparam int Q_FRAC    = 14;
    localparam int R_FRAC    = 28;
    localparam int U_SHIFT   = R_FRAC - FRAC_BITS;
    localparam int ROT_STEPS = 24;
    localparam int ROT_PER_STAGE = 3;
    localparam int ROT_STAGES = ROT_STEPS / ROT_PER_STAGE;
    localparam logic signed [33:0] ROT_GAIN_Q30 = 34'sd652032874;

    localparam logic [31:0] ROT_ANGLE [ROT_STEPS] = '{
        32'h20000000, 32'h12E4051E, 32'h09FB385B, 32'h051111D4, 32'h028B0D43, 32'h0145D7E1,
        32'h00A2F61E, 32'h00517C55, 32'h0028BE53, 32'h00145F2F, 32'h000A2F98, 32'h000517CC,
        32'h00028BE6, 32'h000145F3, 32'h0000A2F9, 32'h0000517D, 32'h000028BE, 32'h0000145F,
        32'h00000A30, 32'h00000518, 32'h0000028C, 32'h00000146, 32'h000000A3, 32'h00000051
    };

    // register indexes of the configuration port
    localparam logic [2:0] REG_BASE_X      = 3'd0;
    localparam logic [2:0] REG_BASE_Y      = 3'd1;
    localparam logic [2:0] REG_BASE_Z      = 3'd2;
    localparam logic [2:0] REG_ORIENTATION = 3'd3;
    localparam logic [2:0] REG_GAIN        = 3'd4;
    localparam logic [2:0] REG_BASE_SIZE   = 3'd5;

    localparam logic [2:0] LAST_RESULT = 3'd5;

    // base plus shift per axis and the saturated total size
    typedef struct packed {
        logic [2:0][32:0] bs;
        logic [31:0]      total;
    } t_side;

    // per-item geometry handed to the result sequencer
    typedef struct packed {
        logic [2:0][32:0] bs;
        logic [2:0][43:0] rel;
        logic [2:0][43:0] ss;
    } t_geo;

    function automatic logic signed [63:0] rnd(input logic signed [63:0] v,
                                               input int unsigned s);
        logic signed [63:0] h;
        begin
            h = 64'sd1 <<< (s - 1);
            if (v >= 0) begin
                rnd = (v + h) >>> s;
            end else begin
                rnd = -((-v + h) >>> s);
            end
        end
    endfunction

    function automatic logic signed [31:0] sat32(input logic signed [63:0] v);
        begin
            if (v > 64'sd2147483647) begin
                sat32 = 32'sh7FFFFFFF;
            end else if (v < -64'sd2147483648) begin
                sat32 = 32'sh80000000;
            end else begin
                sat32 = v[31:0];
            end
        end
    endfunction

endpackage
`default_nettype wire

// ===== hw/rtl/taf_cordic.sv =====
// Pipelined CORDIC for cos and sin of half the yaw angle, sideband carried alongside.
`default_nettype none
module taf_cordic (
    input  wire logic                 i_clk,
    input  wire logic                 i_rst_n,
    input  wire logic                 i_valid,
    input  wire logic [15:0]          i_yaw,
    input  wire taf_pkg::t_side       i_side,
    output logic                      o_valid,
    output logic signed [17:0]        o_cos,
    output logic signed [17:0]        o_sin,
    output taf_pkg::t_side            o_side
);
    import taf_pkg::*;

    typedef struct packed {
        logic signed [33:0] x;
        logic signed [33:0] y;
        logic signed [32:0] z;
        logic               turned;
        t_side              side;
    } t_rot;

    logic r_v [ROT_STAGES+1];
    t_rot r_st [ROT_STAGES+1];
    t_rot n_st [ROT_STAGES];

    // entry: a half angle of a quarter turn or more is reduced by a quarter turn
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v[0] <= 1'b0;
        end else begin
            r_v[0] <= i_valid;
        end
        r_st[0].x      <= ROT_GAIN_Q30;
        r_st[0].y      <= '0;
        r_st[0].z      <= {3'b000, i_yaw[14:0], 15'b0};
        r_st[0].turned <= i_yaw[15];
        r_st[0].side   <= i_side;
    end

    for (genvar k = 0; k < ROT_STAGES; k++) begin : g_stage
        always_comb begin
            t_rot t;
            logic signed [33:0] nx;
            t = r_st[k];
            for (int j = 0; j < ROT_PER_STAGE; j++) begin
                if (t.z >= 0) begin
                    nx  = t.x - (t.y >>> (k * ROT_PER_STAGE + j));
                    t.y = t.y + (t.x >>> (k * ROT_PER_STAGE + j));
                    t.z = t.z - $signed({1'b0, ROT_ANGLE[k * ROT_PER_STAGE + j]});
                end else begin
                    nx  = t.x + (t.y >>> (k * ROT_PER_STAGE + j));
                    t.y = t.y - (t.x >>> (k * ROT_PER_STAGE + j));
                    t.z = t.z + $signed({1'b0, ROT_ANGLE[k * ROT_PER_STAGE + j]});
                end
                t.x = nx;
            end
            n_st[k] = t;
        end

        always_ff @(posedge i_clk) begin
            if (!i_rst_n) begin
                r_v[k+1] <= 1'b0;
            end else begin
                r_v[k+1] <= r_v[k];
            end
            r_st[k+1] <= n_st[k];
        end
    end

    logic signed [17:0] w_xr, w_yr;
    assign w_xr = 18'(rnd(64'(r_st[ROT_STAGES].x), 16));
    assign w_yr = 18'(rnd(64'(r_st[ROT_STAGES].y), 16));

    logic               r_ov;
    logic signed [17:0] r_c, r_s;
    t_side              r_side;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_ov <= 1'b0;
        end else begin
            r_ov <= r_v[ROT_STAGES];
        end
        if (r_st[ROT_STAGES].turned) begin
            r_c <= -w_yr;
            r_s <= w_xr;
        end else begin
            r_c <= w_xr;
            r_s <= w_yr;
        end
        r_side <= r_st[ROT_STAGES].side;
    end

    assign o_valid = r_ov;
    assign o_cos   = r_c;
    assign o_sin   = r_s;
    assign o_side  = r_side;
endmodule
`default_nettype wire

// ===== hw/rtl/taf_quat.sv =====
// Quaternion product, rotated y axis, spacing and offsets in six register stages.
`default_nettype none
module taf_quat (
    input  wire logic                 i_clk,
    input  wire logic                 i_rst_n,
    input  wire logic                 i_valid,
    input  wire logic signed [17:0]   i_cos,
    input  wire logic signed [17:0]   i_sin,
    input  wire taf_pkg::t_side       i_side,
    input  wire logic [63:0]          i_orient,
    input  wire logic signed [31:0]   i_gain,
    output logic                      o_valid,
    output taf_pkg::t_geo             o_geo
);
    import taf_pkg::*;

    logic signed [15:0] w0, x0, y0, z0;
    assign w0 = i_orient[15:0];
    assign x0 = i_orient[31:16];
    assign y0 = i_orient[47:32];
    assign z0 = i_orient[63:48];

    logic [5:0] r_v;
    logic [2:0][32:0] r_bs1, r_bs2, r_bs3, r_bs4, r_bs5;

    // stage 1: product terms of the Hamilton product and gain times total
    logic signed [33:0] r_cw, r_sz, r_cx, r_sy, r_cy, r_sx, r_cz, r_sw;
    logic signed [63:0] r_pl;
    always_ff @(posedge i_clk) begin
        r_cw  <= i_cos * w0;
        r_sz  <= i_sin * z0;
        r_cx  <= i_cos * x0;
        r_sy  <= i_sin * y0;
        r_cy  <= i_cos * y0;
        r_sx  <= i_sin * x0;
        r_cz  <= i_cos * z0;
        r_sw  <= i_sin * w0;
        r_pl  <= i_gain * $signed(i_side.total);
        r_bs1 <= i_side.bs;
    end

    // stage 2: combined quaternion and spacing
    logic signed [17:0] r_qw, r_qx, r_qy, r_qz;
    logic signed [31:0] r_l2;
    always_ff @(posedge i_clk) begin
        r_qw  <= 18'(rnd(64'(r_cw) - 64'(r_sz), Q_FRAC));
        r_qx  <= 18'(rnd(64'(r_cx) - 64'(r_sy), Q_FRAC));
        r_qy  <= 18'(rnd(64'(r_cy) + 64'(r_sx), Q_FRAC));
        r_qz  <= 18'(rnd(64'(r_cz) + 64'(r_sw), Q_FRAC));
        r_l2  <= sat32(rnd(r_pl, FRAC_BITS));
        r_bs2 <= r_bs1;
    end

    // stage 3: quadratic terms of the rotated y axis
    logic signed [35:0] r_xy, r_wz, r_ww, r_xx, r_yy, r_zz, r_yz, r_wx;
    logic signed [31:0] r_l3;
    always_ff @(posedge i_clk) begin
        r_xy  <= r_qx * r_qy;
        r_wz  <= r_qw * r_qz;
        r_ww  <= r_qw * r_qw;
        r_xx  <= r_qx * r_qx;
        r_yy  <= r_qy * r_qy;
        r_zz  <= r_qz * r_qz;
        r_yz  <= r_qy * r_qz;
        r_wx  <= r_qw * r_qx;
        r_l3  <= r_l2;
        r_bs3 <= r_bs2;
    end

    // stage 4: unit y axis in QF
    logic signed [63:0] w_r0, w_r1, w_r2;
    assign w_r0 = 64'sd2 * (64'(r_xy) - 64'(r_wz));
    assign w_r1 = 64'(r_ww) - 64'(r_xx) + 64'(r_yy) - 64'(r_zz);
    assign w_r2 = 64'sd2 * (64'(r_yz) + 64'(r_wx));

    logic signed [27:0] r_u [3];
    logic signed [31:0] r_l4;
    always_ff @(posedge i_clk) begin
        r_u[0] <= 28'(rnd(w_r0, U_SHIFT));
        r_u[1] <= 28'(rnd(w_r1, U_SHIFT));
        r_u[2] <= 28'(rnd(w_r2, U_SHIFT));
        r_l4   <= r_l3;
        r_bs4  <= r_bs3;
    end

    // stage 5: spacing and gain times axis
    logic signed [59:0] r_lu [3];
    logic signed [59:0] r_gu [3];
    always_ff @(posedge i_clk) begin
        for (int a = 0; a < 3; a++) begin
            r_lu[a] <= r_l4 * r_u[a];
            r_gu[a] <= i_gain * r_u[a];
        end
        r_bs5 <= r_bs4;
    end

    // stage 6: halve with rounding
    t_geo r_geo;
    always_ff @(posedge i_clk) begin
        for (int a = 0; a < 3; a++) begin
            r_geo.rel[a] <= 44'(rnd(64'(r_lu[a]), FRAC_BITS + 1));
            r_geo.ss[a]  <= 44'(rnd(64'(r_gu[a]), FRAC_BITS + 1));
        end
        r_geo.bs <= r_bs5;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v <= '0;
        end else begin
            r_v <= {r_v[4:0], i_valid};
        end
    end

    assign o_valid = r_v[5];
    assign o_geo   = r_geo;
endmodule
`default_nettype wire

// ===== hw/rtl/taf_emit.sv =====
// Result sequencer: six saturated results per item, agent 0 then agent 1.
`default_nettype none
module taf_emit (
    input  wire logic                 i_clk,
    input  wire logic                 i_rst_n,
    input  wire logic                 i_valid,
    input  wire taf_pkg::t_geo        i_geo,
    output logic                      o_valid,
    output logic                      o_agent,
    output logic [1:0]                o_axis,
    output logic signed [31:0]        o_position,
    output logic signed [31:0]        o_slope_yaw,
    output logic signed [31:0]        o_slope_size,
    output logic                      o_last
);
    import taf_pkg::*;

    logic       r_act;
    logic [2:0] r_k;
    t_geo       r_geo;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_act <= 1'b0;
            r_k   <= '0;
        end else if (i_valid) begin
            r_act <= 1'b1;
            r_k   <= '0;
        end else if (r_act) begin
            if (r_k == LAST_RESULT) begin
                r_act <= 1'b0;
            end else begin
                r_k <= r_k + 3'd1;
            end
        end
        if (i_valid) begin
            r_geo <= i_geo;
        end
    end

    logic        agent;
    logic [1:0]  ax;
    always_comb begin
        case (r_k)
            3'd0:    begin agent = 1'b0; ax = 2'd0; end
            3'd1:    begin agent = 1'b0; ax = 2'd1; end
            3'd2:    begin agent = 1'b0; ax = 2'd2; end
            3'd3:    begin agent = 1'b1; ax = 2'd0; end
            3'd4:    begin agent = 1'b1; ax = 2'd1; end
            default: begin agent = 1'b1; ax = 2'd2; end
        endcase
    end

    logic signed [63:0] w_rel0, w_rel1, w_rel, w_ss, w_bs, w_pos, w_sy, w_ssn;
    always_comb begin
        w_rel0 = 64'($signed(r_geo.rel[0]));
        w_rel1 = 64'($signed(r_geo.rel[1]));
        case (ax)
            2'd0: begin
                w_rel = w_rel0;
                w_ss  = 64'($signed(r_geo.ss[0]));
                w_bs  = 64'($signed(r_geo.bs[0]));
                w_sy  = -w_rel1;
            end
            2'd1: begin
                w_rel = w_rel1;
                w_ss  = 64'($signed(r_geo.ss[1]));
                w_bs  = 64'($signed(r_geo.bs[1]));
                w_sy  = w_rel0;
            end
            default: begin
                w_rel = 64'($signed(r_geo.rel[2]));
                w_ss  = 64'($signed(r_geo.ss[2]));
                w_bs  = 64'($signed(r_geo.bs[2]));
                w_sy  = '0;
            end
        endcase
        if (agent) begin
            w_pos = w_bs - w_rel;
            w_sy  = -w_sy;
            w_ssn = -w_ss;
        end else begin
            w_pos = w_bs + w_rel;
            w_ssn = w_ss;
        end
    end

    assign o_valid      = r_act;
    assign o_agent      = agent;
    assign o_axis       = ax;
    assign o_position   = sat32(w_pos);
    assign o_slope_yaw  = sat32(w_sy);
    assign o_slope_size = sat32(w_ssn);
    assign o_last       = r_act && (r_k == LAST_RESULT);
endmodule
`default_nettype wire

// ===== hw/rtl/two_agent_abreast_formation.sv =====
// Top level of the two-agent abreast formation block.
`default_nettype none
// Each request is a pose change (shift x/y/z, yaw as a binary angle, size change). The block
// answers with six results on consecutive cycles, agent 0 axes x, y, z then agent 1 axes
// x, y, z, each marked by o_valid for exactly one cycle; o_last flags the sixth. The receiver
// cannot stall: results must be taken as they appear. A request is taken when start is high
// and busy is low; busy then stays high while the spacing counter r_gap runs down, and no
// request is taken until it drops, a spacing set by the single result port delivering six
// results per request. Each request passes a 24-step CORDIC in eight stages of three steps,
// then six multiply and round stages for the quaternion, the rotated y axis, the spacing
// and the offsets. Configuration writes (index 0..5, data in the low bits) are always ready
// and belong in idle time only; other indexes are dropped.
module two_agent_abreast_formation (
    input  wire logic                 i_clk,
    input  wire logic                 i_rst_n,
    input  wire logic                 start,
    output logic                      busy,
    input  wire logic signed [31:0]   i_shift_x,
    input  wire logic signed [31:0]   i_shift_y,
    input  wire logic signed [31:0]   i_shift_z,
    input  wire logic [15:0]          i_yaw_angle,
    input  wire logic signed [31:0]   i_size_change,
    input  wire logic                 i_cfg_valid,
    output logic                      o_cfg_ready,
    input  wire logic [2:0]           i_cfg_index,
    input  wire logic [63:0]          i_cfg_data,
    output logic                      o_valid,
    output logic                      o_agent,
    output logic [1:0]                o_axis,
    output logic signed [31:0]        o_position,
    output logic signed [31:0]        o_slope_yaw,
    output logic signed [31:0]        o_slope_size,
    output logic                      o_last
);
    import taf_pkg::*;

    // configuration registers
    logic signed [31:0] r_base_x, r_base_y, r_base_z, r_gain, r_base_size;
    logic [63:0]        r_orient;

    assign o_cfg_ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_base_x    <= '0;
            r_base_y    <= '0;
            r_base_z    <= '0;
            r_orient    <= 64'd16384;
            r_gain      <= 32'sd65536;
            r_base_size <= 32'sd65536;
        end else if (i_cfg_valid) begin
            case (i_cfg_index)
                REG_BASE_X:      r_base_x    <= i_cfg_data[31:0];
                REG_BASE_Y:      r_base_y    <= i_cfg_data[31:0];
                REG_BASE_Z:      r_base_z    <= i_cfg_data[31:0];
                REG_ORIENTATION: r_orient    <= i_cfg_data;
                REG_GAIN:        r_gain      <= i_cfg_data[31:0];
                REG_BASE_SIZE:   r_base_size <= i_cfg_data[31:0];
                default: ;
            endcase
        end
    end

    // request spacing: hold busy after each accepted request until r_gap has counted down
    logic       accept;
    logic [2:0] r_gap;
    assign accept = start && !busy;
    assign busy   = (r_gap != 3'd0);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_gap <= '0;
        end else if (accept) begin
            r_gap <= LAST_RESULT;
        end else if (r_gap != 3'd0) begin
            r_gap <= r_gap - 3'd1;
        end
    end

    // sideband formed at entry: base plus shift, and the saturated total size
    t_side side_in;
    always_comb begin
        side_in.bs[0] = 33'(r_base_x) + 33'(i_shift_x);
        side_in.bs[1] = 33'(r_base_y) + 33'(i_shift_y);
        side_in.bs[2] = 33'(r_base_z) + 33'(i_shift_z);
        side_in.total = sat32(64'(r_base_size) + 64'(i_size_change));
    end

    logic               cor_valid;
    logic signed [17:0] cor_cos, cor_sin;
    t_side              cor_side;

    taf_cordic u_cordic (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (accept),
        .i_yaw   (i_yaw_angle),
        .i_side  (side_in),
        .o_valid (cor_valid),
        .o_cos   (cor_cos),
        .o_sin   (cor_sin),
        .o_side  (cor_side)
    );

    logic geo_valid;
    t_geo geo;

    taf_quat u_quat (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_valid  (cor_valid),
        .i_cos    (cor_cos),
        .i_sin    (cor_sin),
        .i_side   (cor_side),
        .i_orient (r_orient),
        .i_gain   (r_gain),
        .o_valid  (geo_valid),
        .o_geo    (geo)
    );

    // busy spaces the requests, so the sequencer is always free
    taf_emit u_emit (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_valid      (geo_valid),
        .i_geo        (geo),
        .o_valid      (o_valid),
        .o_agent      (o_agent),
        .o_axis       (o_axis),
        .o_position   (o_position),
        .o_slope_yaw  (o_slope_yaw),
        .o_slope_size (o_slope_size),
        .o_last       (o_last)
    );

`ifndef SYNTHESIS
    a_last_is_agent1_z: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && o_last |-> o_agent && (o_axis == 2'd2))
        else $error("last result not agent 1 axis z");
    a_burst_continues: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && !o_last |=> o_valid)
        else $error("result burst broken");
    a_busy_after_accept: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        start && !busy |=> busy)
        else $error("busy not raised after request");
    a_no_z_yaw_slope: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && (o_axis == 2'd2) |-> (o_slope_yaw == 32'sd0))
        else $error("z yaw slope nonzero");
`endif
endmodule
`default_nettype wire

// ===== tb/tb_two_agent_abreast_formation.sv =====
// Testbench for the two-agent abreast formation block: predicted positions and slopes.
`timescale 1ns / 1ps
module tb_two_agent_abreast_formation;
    import taf_pkg::*;

    localparam int LATENCY = 17;

    typedef struct {
        logic signed [31:0] sx, sy, sz;
        logic [15:0]        yaw;
        logic signed [31:0] dsize;
    } t_pose;

    typedef struct {
        logic               agent;
        logic [1:0]         axis;
        logic signed [31:0] pos, syaw, ssize;
        logic               last;
    } t_coord;

    typedef struct {
        bit                 is_cfg;
        logic [2:0]         idx;
        logic [63:0]        data;
        t_pose              p;
    } t_job;

    logic i_clk = 1'b0;
    logic i_rst_n = 1'b0;
    logic start = 1'b0;
    logic busy;
    logic signed [31:0] i_shift_x = '0, i_shift_y = '0, i_shift_z = '0, i_size_change = '0;
    logic [15:0] i_yaw_angle = '0;
    logic i_cfg_valid = 1'b0;
    logic o_cfg_ready;
    logic [2:0] i_cfg_index = '0;
    logic [63:0] i_cfg_data = '0;
    logic o_valid, o_agent, o_last;
    logic [1:0] o_axis;
    logic signed [31:0] o_position, o_slope_yaw, o_slope_size;

    two_agent_abreast_formation u_top (.*);

    always begin
        #5 i_clk = 1'b1;
        #5 i_clk = 1'b0;
    end

    // predictor copy of the configuration registers
    logic signed [31:0] cfg_base [3];
    logic [63:0]        cfg_orient;
    logic signed [31:0] cfg_gain, cfg_size;

    t_job   pending_jobs[$];
    t_coord expected_coords[$];
    int     mismatches = 0;
    int     send_idle_pct = 0;

    function automatic longint rshr(longint v, int s);
        longint h;
        h = longint'(1) << (s - 1);
        if (v >= 0) return (v + h) >>> s;
        return -((-v + h) >>> s);
    endfunction

    function automatic longint fshr(longint v, int s);
        if (v >= 0) return v >>> s;
        return -(((-v) - 1) >>> s) - 1;
    endfunction

    function automatic longint clip32(longint v);
        if (v > 64'sd2147483647) return 64'sd2147483647;
        if (v < -64'sd2147483648) return -64'sd2147483648;
        return v;
    endfunction

    // CORDIC of half the yaw, Q2.14 cosine and sine
    task automatic half_yaw(input logic [15:0] yaw, output longint c, output longint s);
        longint phi, x, y, z, nx;
        bit turned;
        phi = longint'(yaw) << 15;
        turned = phi >= (longint'(1) << 30);
        if (turned) phi -= longint'(1) << 30;
        x = longint'(ROT_GAIN_Q30);
        y = 0;
        z = phi;
        for (int i = 0; i < ROT_STEPS; i++) begin
            if (z >= 0) begin
                nx = x - fshr(y, i);
                y = y + fshr(x, i);
                z -= longint'(ROT_ANGLE[i]);
            end else begin
                nx = x + fshr(y, i);
                y = y - fshr(x, i);
                z += longint'(ROT_ANGLE[i]);
            end
            x = nx;
        end
        x = rshr(x, 16);
        y = rshr(y, 16);
        if (turned) begin
            c = -y;
            s = x;
        end else begin
            c = x;
            s = y;
        end
    endtask

    // work out the six coordinates a pose change yields
    task automatic predict_formation(input t_pose p);
        longint c, s, w0, x0, y0, z0, qw, qx, qy, qz, total, l, sg, pv, sy, ss;
        longint r[3], u[3], rel[3], sh[3];
        t_coord e;
        half_yaw(p.yaw, c, s);
        w0 = longint'($signed(cfg_orient[15:0]));
        x0 = longint'($signed(cfg_orient[31:16]));
        y0 = longint'($signed(cfg_orient[47:32]));
        z0 = longint'($signed(cfg_orient[63:48]));
        qw = rshr(c * w0 - s * z0, 14);
        qx = rshr(c * x0 - s * y0, 14);
        qy = rshr(c * y0 + s * x0, 14);
        qz = rshr(c * z0 + s * w0, 14);
        r[0] = 2 * (qx * qy - qw * qz);
        r[1] = qw * qw - qx * qx + qy * qy - qz * qz;
        r[2] = 2 * (qy * qz + qw * qx);
        total = clip32(longint'(cfg_size) + longint'(p.dsize));
        l = clip32(rshr(longint'(cfg_gain) * total, FRAC_BITS));
        for (int a = 0; a < 3; a++) begin
            u[a] = rshr(r[a], R_FRAC - FRAC_BITS);
            rel[a] = rshr(l * u[a], FRAC_BITS + 1);
        end
        sh[0] = p.sx;
        sh[1] = p.sy;
        sh[2] = p.sz;
        for (int k = 0; k < 6; k++) begin
            int ax;
            ax = k % 3;
            sg = (k >= 3) ? -1 : 1;
            pv = clip32(longint'(cfg_base[ax]) + sh[ax] + sg * rel[ax]);
            if (ax == 0) sy = clip32(-sg * rel[1]);
            else if (ax == 1) sy = clip32(sg * rel[0]);
            else sy = 0;
            ss = clip32(sg * rshr(longint'(cfg_gain) * u[ax], FRAC_BITS + 1));
            e.agent = (k >= 3);
            e.axis = ax[1:0];
            e.pos = pv[31:0];
            e.syaw = sy[31:0];
            e.ssize = ss[31:0];
            e.last = (k == 5);
            expected_coords.push_back(e);
        end
    endtask

    task automatic apply_cfg(input logic [2:0] idx, input logic [63:0] d);
        case (idx)
            REG_BASE_X:      cfg_base[0] = d[31:0];
            REG_BASE_Y:      cfg_base[1] = d[31:0];
            REG_BASE_Z:      cfg_base[2] = d[31:0];
            REG_ORIENTATION: cfg_orient = d;
            REG_GAIN:        cfg_gain = d[31:0];
            REG_BASE_SIZE:   cfg_size = d[31:0];
            default: ;
        endcase
    endtask

    // Driver: pop one request at a time; predict at the accepting edge.
    // Config entries wait until the block has drained.
    int drain_wait = 0;
    always @(posedge i_clk) begin
        if (i_rst_n) begin
            if (i_cfg_valid && o_cfg_ready) begin
                apply_cfg(i_cfg_index, i_cfg_data);
                i_cfg_valid <= 1'b0;
            end else if (start && !busy) begin
                predict_formation('{i_shift_x, i_shift_y, i_shift_z, i_yaw_angle,
                                    i_size_change});
                start <= 1'b0;
            end else if (!start && !i_cfg_valid && pending_jobs.size() > 0) begin
                if (pending_jobs[0].is_cfg) begin
                    // hold config until every expected result has come out
                    if (expected_coords.size() == 0) begin
                        if (drain_wait >= LATENCY + 4) begin
                            t_job j;
                            j = pending_jobs.pop_front();
                            i_cfg_index <= j.idx;
                            i_cfg_data <= j.data;
                            i_cfg_valid <= 1'b1;
                            drain_wait <= 0;
                        end else begin
                            drain_wait <= drain_wait + 1;
                        end
                    end else begin
                        drain_wait <= 0;
                    end
                end else if ($urandom_range(99) >= send_idle_pct) begin
                    t_job j;
                    j = pending_jobs.pop_front();
                    i_shift_x <= j.p.sx;
                    i_shift_y <= j.p.sy;
                    i_shift_z <= j.p.sz;
                    i_yaw_angle <= j.p.yaw;
                    i_size_change <= j.p.dsize;
                    start <= 1'b1;
                end
            end
        end
    end

    // Monitor: compare each strobed result with the oldest expectation.
    always @(posedge i_clk) begin
        if (i_rst_n && o_valid) begin
            if (expected_coords.size() == 0) begin
                mismatches++;
                if (mismatches <= 10)
                    $display("unexpected result agent %0d axis %0d", o_agent, o_axis);
            end else begin
                t_coord e;
                e = expected_coords.pop_front();
                if (o_agent !== e.agent || o_axis !== e.axis || o_position !== e.pos ||
                    o_slope_yaw !== e.syaw || o_slope_size !== e.ssize ||
                    o_last !== e.last) begin
                    mismatches++;
                    if (mismatches <= 10)
                        $display("mismatch exp a%0d x%0d p%0d sy%0d ss%0d l%0d got a%0d x%0d p%0d sy%0d ss%0d l%0d",
                                 e.agent, e.axis, e.pos, e.syaw, e.ssize, e.last,
                                 o_agent, o_axis, o_position, o_slope_yaw,
                                 o_slope_size, o_last);
                end
            end
        end
    end

    function automatic logic [31:0] rand_q();
        case ($urandom_range(5))
            0: return 32'h7FFFFFFF;
            1: return 32'h80000000;
            2: return $urandom;
            default: return $signed($urandom_range(16'hFFFF, 0)) - 32'sd32768 <<< 4;
        endcase
    endfunction

    task automatic add_pose(input logic [31:0] x, y, z, input logic [15:0] yaw,
                            input logic [31:0] ds);
        t_job j;
        j.is_cfg = 1'b0;
        j.p = '{x, y, z, yaw, ds};
        pending_jobs.push_back(j);
    endtask

    task automatic add_cfg(input logic [2:0] idx, input logic [63:0] d);
        t_job j;
        j.is_cfg = 1'b1;
        j.idx = idx;
        j.data = d;
        pending_jobs.push_back(j);
    endtask

    function automatic logic [63:0] rand_orient();
        logic [63:0] q;
        // mostly near-unit quaternions, some arbitrary halves
        if ($urandom_range(3) == 0) q = {$urandom, $urandom};
        else q = {16'($urandom_range(8000)) - 16'd4000, 16'($urandom_range(8000)) - 16'd4000,
                  16'($urandom_range(8000)) - 16'd4000, 16'd16384 - 16'($urandom_range(4000))};
        return q;
    endfunction

    task automatic wait_drained();
        while (pending_jobs.size() > 0 || start || i_cfg_valid) @(posedge i_clk);
    endtask

    initial begin
        cfg_base = '{0, 0, 0};
        cfg_orient = 64'd16384;
        cfg_gain = 32'sd65536;
        cfg_size = 32'sd65536;
        repeat (3) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // directed: field extremes, yaw quadrants, saturation
        add_pose(0, 0, 0, 16'h0000, 0);
        add_pose(0, 0, 0, 16'h4000, 0);
        add_pose(0, 0, 0, 16'h8000, 0);
        add_pose(0, 0, 0, 16'hC000, 0);
        add_pose(0, 0, 0, 16'hFFFF, 0);
        add_pose(32'h7FFFFFFF, 32'h7FFFFFFF, 32'h7FFFFFFF, 16'h2000, 32'h7FFFFFFF);
        add_pose(32'h80000000, 32'h80000000, 32'h80000000, 16'h6000, 32'h80000000);
        add_pose(32'hFFFFFFFF, 32'h1, 32'h10000, 16'h1234, 32'hFFFF0000);
        add_cfg(REG_GAIN, 64'h7FFFFFFF);
        add_cfg(REG_BASE_SIZE, 64'h7FFFFFFF);
        add_cfg(REG_BASE_X, 64'h7FFFFFFF);
        add_cfg(REG_BASE_Y, 64'h80000000);
        add_cfg(REG_BASE_Z, 64'hFFFFFFFF);
        add_pose(32'h7FFFFFFF, 32'h80000000, 0, 16'h3000, 32'h7FFFFFFF);
        add_pose(32'h80000000, 32'h7FFFFFFF, 0, 16'hA000, 32'h80000000);
        // non-unit quaternion, and an ignored out-of-range index
        add_cfg(REG_ORIENTATION, 64'h7FFF_8000_7FFF_8000);
        add_cfg(3'd7, 64'h0);
        add_cfg(REG_GAIN, 64'h80000000);
        add_cfg(REG_BASE_SIZE, 64'h80000000);
        add_pose(0, 0, 0, 16'h5555, 32'h7FFFFFFF);
        add_pose(0, 0, 0, 16'hAAAA, 32'h80000000);
        add_cfg(3'd6, 64'hFFFF_FFFF_FFFF_FFFF);
        send_idle_pct = 14;

        // random phases, each with its own configuration
        for (int ph = 0; ph < 12; ph++) begin
            if (ph == 4) begin
                wait_drained();
                send_idle_pct = 51;
            end
            if (ph == 8) begin
                wait_drained();
                send_idle_pct = 0;
            end
            add_cfg(REG_BASE_X, 64'(rand_q()));
            add_cfg(REG_BASE_Y, 64'(rand_q()));
            add_cfg(REG_BASE_Z, 64'(rand_q()));
            add_cfg(REG_ORIENTATION, rand_orient());
            add_cfg(REG_GAIN,
                    64'((ph % 3 == 0) ? rand_q() : 32'($urandom_range(196608))));
            add_cfg(REG_BASE_SIZE,
                    64'((ph % 3 == 0) ? rand_q() : 32'($urandom_range(262144))));
            for (int n = 0; n < 28; n++) begin
                if ($urandom_range(3) == 0)
                    add_pose(rand_q(), rand_q(), rand_q(), 16'($urandom), rand_q());
                else
                    add_pose($urandom_range(65535) << 4, $urandom_range(65535) << 4,
                             $urandom_range(65535) << 4, 16'($urandom),
                             32'($urandom_range(131072)) - 32'd65536);
            end
        end
        wait_drained();
        while (expected_coords.size() > 0) @(posedge i_clk);
        repeat (LATENCY + 8) @(posedge i_clk);
        if (mismatches == 0 && expected_coords.size() == 0) begin
            $display("status: pass");
        end else begin
            $display("status: fail");
        end
        $finish;
    end

    // generous limit for all queued requests and configuration writes
    initial begin
        #2000000;
        $display("status: fail");
        $finish;
    end

endmodule

// ===== files.f =====
hw/rtl/taf_pkg.sv
hw/rtl/taf_cordic.sv
hw/rtl/taf_quat.sv
hw/rtl/taf_emit.sv
hw/rtl/two_agent_abreast_formation.sv
tb/tb_two_agent_abreast_formation.sv
